// ----- src/asp_pkg.sv -----
// shared constants, command codes and the depth-to-shift function
// for the autostereogram pixel generator; no dependencies
package asp_pkg;

    localparam int DEF_MAX_IMAGE_WIDTH  = 2048;
    localparam int DEF_MAX_PATTERN_SIDE = 128;

    localparam int DEPTH_STEPS = 20;

    localparam int CMD_W         = 2;
    localparam int COLOR_W       = 32;
    localparam int TEXEL_POS_W   = 7;
    localparam int DEPTH_W       = 8;
    localparam int IMAGE_WIDTH_W = 12;
    localparam int PATTERN_DIM_W = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 12;
    localparam int SHIFT_W       = 5;

    localparam logic [IMAGE_WIDTH_W-1:0] RST_IMAGE_WIDTH   = 12'd1440;
    localparam logic [PATTERN_DIM_W-1:0] RST_PATTERN_WIDTH = 8'd128;
    localparam logic [PATTERN_DIM_W-1:0] RST_PATTERN_ROWS  = 8'd128;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_DEPTH = 2'd1,
        CMD_FRAME = 2'd2
    } t_command;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_ROWS  = 2'd2;

    // floor((255 - depth) * 20 / 255), division by 255 done as add and shift
    function automatic logic [SHIFT_W-1:0] depth_shift(input logic [DEPTH_W-1:0] depth);
        logic [12:0] n;
        logic [12:0] x;
        logic [12:0] q;
        n = 13'(8'd255 - depth);
        x = n * 13'(DEPTH_STEPS);
        q = (x + 13'd1 + (x >> 8)) >> 8;
        return q[SHIFT_W-1:0];
    endfunction

endpackage

// ----- src/asp_ram.sv -----
// generic single-clock ram, one write port and one registered read port
// read of the address written in the same cycle returns the old word; no dependencies
module asp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/autostereogram_pixel_generator.sv -----
// autostereogram pixel generator top level, uses asp_pkg and asp_ram
// a depth pixel passes the registered store read and the resolve stage into the output
// queue, from which it is taken; throughput: one transaction per cycle for any command
// while o_ready is high, one pattern read and one row store read and write per pixel; a
// pattern rows write may stall input while the row counter is reduced; synchronous
// active-low reset clears counters, registers and queue, not the stores
module autostereogram_pixel_generator #(
    parameter int MAX_IMAGE_WIDTH  = asp_pkg::DEF_MAX_IMAGE_WIDTH,
    parameter int MAX_PATTERN_SIDE = asp_pkg::DEF_MAX_PATTERN_SIDE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input transactions
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [asp_pkg::CMD_W-1:0]       i_command,
    input  logic [asp_pkg::COLOR_W-1:0]     i_texel_color,
    input  logic [asp_pkg::TEXEL_POS_W-1:0] i_texel_col,
    input  logic [asp_pkg::TEXEL_POS_W-1:0] i_texel_row,
    input  logic [asp_pkg::DEPTH_W-1:0]     i_depth_red,
    // output transactions
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [asp_pkg::COLOR_W-1:0]     o_pixel_color,
    output logic                            o_end_of_row,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [asp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [asp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import asp_pkg::*;

    // column and pattern widths
    localparam int CW     = $clog2(MAX_IMAGE_WIDTH);
    localparam int IWW    = CW + 1;
    localparam int ICMPW  = (IWW > IMAGE_WIDTH_W) ? IWW : IMAGE_WIDTH_W;
    localparam int PSW    = $clog2(MAX_PATTERN_SIDE);
    localparam int PWW    = $clog2(MAX_PATTERN_SIDE + 1);
    localparam int PCMPW  = (PWW > PATTERN_DIM_W) ? PWW : PATTERN_DIM_W;
    localparam int PDEPTH = MAX_PATTERN_SIDE * MAX_PATTERN_SIDE;
    localparam int PAW    = $clog2(PDEPTH);
    localparam int SUMW   = CW + 1;
    localparam int GW     = (SUMW > PWW) ? SUMW : PWW;
    // output queue
    localparam int QDEPTH = 3;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int OCW    = QCW + 1;

    typedef struct packed {
        logic          use_row;
        logic [CW-1:0] idx;
        logic [CW-1:0] col;
        logic          last;
    } t_s1_item;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_out_item;

    // configuration registers
    logic [IMAGE_WIDTH_W-1:0] r_image_width;
    logic [PATTERN_DIM_W-1:0] r_pattern_width;
    logic [PATTERN_DIM_W-1:0] r_pattern_rows;

    // raster counters; r_prow_base keeps the row count as counted, r_prow the
    // copy reduced below the current height
    logic [CW-1:0]  r_col;
    logic [PSW-1:0] r_prow;
    logic [PSW-1:0] r_prow_base;

    // resolve stage and forwarding of the last row store write
    logic           r_s1_valid;
    t_s1_item       r_s1;
    logic           r_fwd_valid;
    logic [CW-1:0]  r_fwd_addr;
    logic [COLOR_W-1:0] r_fwd_data;

    // output queue
    t_out_item      r_q [QDEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QCW-1:0] r_count;

    // clamped registers
    logic [ICMPW-1:0] iw_ext;
    logic [IWW-1:0]   iw_c;
    logic [PCMPW-1:0] pw_ext;
    logic [PCMPW-1:0] ph_ext;
    logic [PWW-1:0]   pw_c;
    logic [PWW-1:0]   ph_c;

    logic                accept;
    logic                is_depth;
    logic                is_frame;
    logic                load_ok;
    logic [SHIFT_W-1:0]  shift;
    logic [GW-1:0]       col_g;
    logic [GW-1:0]       sum_g;
    logic [GW-1:0]       pw_g;
    logic [GW-1:0]       pc_g;
    logic                use_row;
    logic [PSW-1:0]      pc;
    logic [CW-1:0]       idx;
    logic [IWW-1:0]      col_next;
    logic                last;
    logic [PWW-1:0]      prow_next;
    logic [PSW-1:0]      prow_wrap;
    logic                prow_fix;
    logic                prow_reload;
    logic [OCW-1:0]      occupancy;
    logic [PAW-1:0]      pat_raddr;
    logic [PAW-1:0]      pat_waddr;
    logic [COLOR_W-1:0]  pat_rdata;
    logic [COLOR_W-1:0]  row_rdata;
    logic                fwd_hit;
    logic [COLOR_W-1:0]  s1_color;
    logic                push;
    logic                pop;
    t_out_item           q_head;

    // clamp registers into their legal ranges
    assign iw_ext = ICMPW'(r_image_width);
    assign pw_ext = PCMPW'(r_pattern_width);
    assign ph_ext = PCMPW'(r_pattern_rows);

    always_comb begin
        if (iw_ext == '0) begin
            iw_c = IWW'(1);
        end else if (iw_ext > ICMPW'(MAX_IMAGE_WIDTH)) begin
            iw_c = IWW'(MAX_IMAGE_WIDTH);
        end else begin
            iw_c = IWW'(iw_ext);
        end

        if (pw_ext < PCMPW'(DEPTH_STEPS + 1)) begin
            pw_c = PWW'(DEPTH_STEPS + 1);
        end else if (pw_ext > PCMPW'(MAX_PATTERN_SIDE)) begin
            pw_c = PWW'(MAX_PATTERN_SIDE);
        end else begin
            pw_c = PWW'(pw_ext);
        end

        if (ph_ext == '0) begin
            ph_c = PWW'(1);
        end else if (ph_ext > PCMPW'(MAX_PATTERN_SIDE)) begin
            ph_c = PWW'(MAX_PATTERN_SIDE);
        end else begin
            ph_c = PWW'(ph_ext);
        end
    end

    // row counter left at or above a lowered height is reduced before input resumes
    assign prow_fix    = PWW'(r_prow) >= ph_c;
    assign prow_reload = i_cfg_we && (i_cfg_index == CFG_PATTERN_ROWS);

    // two stages plus queued results must fit in the queue, so no path from i_ready
    assign occupancy = OCW'(r_count) + OCW'(r_s1_valid);
    assign o_ready   = !prow_fix && (occupancy < OCW'(QDEPTH));

    assign accept   = i_valid && o_ready;
    assign is_depth = accept && (i_command == CMD_DEPTH);
    assign is_frame = accept && (i_command == CMD_FRAME);
    assign load_ok  = accept && (i_command == CMD_LOAD)
                   && (PCMPW'(i_texel_col) < PCMPW'(MAX_PATTERN_SIDE))
                   && (PCMPW'(i_texel_row) < PCMPW'(MAX_PATTERN_SIDE));

    // address generation for a depth pixel
    assign shift   = depth_shift(i_depth_red);
    assign col_g   = GW'(r_col);
    assign sum_g   = GW'(r_col) + GW'(shift);
    assign pw_g    = GW'(pw_c);
    assign use_row = col_g >= pw_g;
    // for a pattern pixel col + shift stays below twice the pattern width, one subtract wraps it
    assign pc_g    = (sum_g >= pw_g) ? (sum_g - pw_g) : sum_g;
    assign pc      = PSW'(pc_g);
    // earlier pixel of this row, always left of the current column
    assign idx     = CW'(sum_g - pw_g);

    assign pat_raddr = PAW'(r_prow) * PAW'(MAX_PATTERN_SIDE) + PAW'(pc);
    assign pat_waddr = PAW'(i_texel_row) * PAW'(MAX_PATTERN_SIDE) + PAW'(i_texel_col);

    assign col_next  = IWW'(r_col) + IWW'(1);
    assign last      = col_next >= iw_c;
    assign prow_next = PWW'(r_prow) + PWW'(1);
    assign prow_wrap = (prow_next >= ph_c) ? '0 : PSW'(prow_next);

    asp_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PDEPTH)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr (pat_waddr),
        .i_wdata (i_texel_color),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    asp_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_IMAGE_WIDTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1.col),
        .i_wdata (s1_color),
        .i_raddr (idx),
        .o_rdata (row_rdata)
    );

    // resolve stage: the previous pixel wrote the row store at the same edge as
    // this read, and the ram returns the old word, so take it from the bypass
    assign fwd_hit  = r_fwd_valid && (r_fwd_addr == r_s1.idx);
    assign s1_color = !r_s1.use_row ? pat_rdata
                    : (fwd_hit ? r_fwd_data : row_rdata);

    assign push   = r_s1_valid;
    assign pop    = o_valid && i_ready;
    assign q_head = r_q[r_rp];

    assign o_valid       = r_count != '0;
    assign o_pixel_color = q_head.color;
    assign o_end_of_row  = q_head.last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= RST_IMAGE_WIDTH;
            r_pattern_width  <= RST_PATTERN_WIDTH;
            r_pattern_rows   <= RST_PATTERN_ROWS;
            r_col            <= '0;
            r_prow           <= '0;
            r_prow_base      <= '0;
            r_s1_valid       <= 1'b0;
            r_fwd_valid      <= 1'b0;
            r_wp             <= '0;
            r_rp             <= '0;
            r_count          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        r_image_width <= i_cfg_data[IMAGE_WIDTH_W-1:0];
                    end
                    CFG_PATTERN_WIDTH: begin
                        r_pattern_width <= i_cfg_data[PATTERN_DIM_W-1:0];
                    end
                    CFG_PATTERN_ROWS: begin
                        r_pattern_rows <= i_cfg_data[PATTERN_DIM_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (is_frame) begin
                r_col       <= '0;
                r_prow_base <= '0;
            end else if (is_depth) begin
                if (last) begin
                    r_col       <= '0;
                    r_prow_base <= prow_wrap;
                end else begin
                    r_col <= CW'(col_next);
                end
            end

            // a new height restarts the reduction from the row count as counted
            if (prow_reload) begin
                r_prow <= r_prow_base;
            end else if (prow_fix) begin
                r_prow <= PSW'(PWW'(r_prow) - ph_c);
            end else if (is_frame) begin
                r_prow <= '0;
            end else if (is_depth && last) begin
                r_prow <= prow_wrap;
            end

            r_s1_valid  <= is_depth;
            r_fwd_valid <= r_s1_valid;

            if (push) begin
                r_wp <= (r_wp == QPW'(QDEPTH - 1)) ? '0 : r_wp + QPW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QPW'(QDEPTH - 1)) ? '0 : r_rp + QPW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1.use_row <= use_row;
        r_s1.idx     <= idx;
        r_s1.col     <= r_col;
        r_s1.last    <= last;
        r_fwd_addr   <= r_s1.col;
        r_fwd_data   <= s1_color;
        if (push) begin
            r_q[r_wp].color <= s1_color;
            r_q[r_wp].last  <= r_s1.last;
        end
    end

    // a resolved pixel always finds room in the queue
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_count < QCW'(QDEPTH)))
        else $error("resolved pixel with a full output queue");

    // a row store read always points left of the pixel being written
    a_row_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.use_row) |-> (r_s1.idx < r_s1.col))
        else $error("row store read not behind current column");

    // no pixel is taken while the pattern row counter is out of range
    a_prow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (PWW'(r_prow) < ph_c))
        else $error("input accepted with pattern row at or above height");

    // the bypass only ever holds the write of the cycle just before
    a_fwd_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> $past(r_s1_valid))
        else $error("bypass valid without a preceding row store write");

endmodule
